// File: design/rbd_pkg.sv
// rbd_pkg: shared constants and types for the RGB box downscaler.
// No dependencies.
`timescale 1ns / 1ps
package rbd_pkg;
  localparam int MAX_OUT_WIDTH_D = 1024;
  localparam int MAX_FACTOR_D = 16;
  localparam int MAX_IN_DIM_D = 4096;
  localparam int CFG_W = 13;
  localparam int SUM_W = 8 + 2 * $clog2(MAX_FACTOR_D);

  typedef enum logic [2:0] {
    REG_HFACTOR = 3'd0,
    REG_VFACTOR = 3'd1,
    REG_IN_WIDTH = 3'd2,
    REG_IN_HEIGHT = 3'd3,
    REG_OUT_WIDTH = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    DIV_IDLE = 2'd0,
    DIV_RUN = 2'd1,
    DIV_DONE = 2'd2
  } div_state_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] den;
    logic last;
  } div_req_t;
endpackage

// File: design/rgb_box_downscaler.sv
// rgb_box_downscaler: top level; counters, accumulator line memory, output divider.
// Depends on rbd_pkg and rbd_divider.
//
//  channel | handshake         | payload
//  cfg     | cfg_we            | cfg_index, cfg_data
//  pixel   | in_valid/in_ready | red_in, green_in, blue_in
//  result  | out_valid/out_ready | red_out, green_out, blue_out, line_end
//
// Each pixel does an accumulator read, then an add and write back before the next is taken.
// A pixel that finishes a block holds the input through the 16-step divider:
// its result is valid once the divider is done and the output register takes it,
// and the next beat is taken only after that, which waits while the output register is full.
// No clearing pass; accumulator line uncleared.
// rst is synchronous; counters and handshake state clear, memory does not.
`timescale 1ns / 1ps
module rgb_box_downscaler import rbd_pkg::*; #(
  parameter int MAX_OUT_WIDTH = MAX_OUT_WIDTH_D,
  parameter int MAX_IN_DIM = MAX_IN_DIM_D
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  output logic out_valid,
  input  logic out_ready,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic line_end
);
  localparam int AW = $clog2(MAX_OUT_WIDTH);
  localparam int DW = $clog2(MAX_IN_DIM) + 1;
  localparam int FW = $clog2(MAX_FACTOR_D) + 1;
  localparam int OW = $clog2(MAX_OUT_WIDTH) + 1;

  logic [4:0] hf_reg, vf_reg;
  logic [12:0] iw_reg, ih_reg;
  logic [10:0] ow_reg;
  logic [FW-1:0] hf, vf;
  logic [DW-1:0] iw, ih;
  logic [OW-1:0] ow;

  logic [DW-1:0] in_col, in_row;
  logic [OW-1:0] out_col;
  logic [FW-1:0] pix_grp, row_grp;

  logic [3*SUM_W-1:0] mem [MAX_OUT_WIDTH];
  logic [3*SUM_W-1:0] rdata;
  logic phase;
  logic [7:0] pr, pg, pb;
  logic p_first, p_emit, p_last, p_active;
  logic [AW-1:0] p_addr;
  logic [SUM_W-1:0] sr, sg, sb;
  div_req_t req;
  logic dstart, dbusy, ddone, dtake, dlast;
  logic [7:0] qr, qg, qb;

  always_ff @(posedge clk) begin
    if (rst) begin
      hf_reg <= 5'd1;
      vf_reg <= 5'd1;
      iw_reg <= 13'd1024;
      ih_reg <= 13'd1024;
      ow_reg <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HFACTOR: hf_reg <= cfg_data[4:0];
        REG_VFACTOR: vf_reg <= cfg_data[4:0];
        REG_IN_WIDTH: iw_reg <= cfg_data;
        REG_IN_HEIGHT: ih_reg <= cfg_data;
        REG_OUT_WIDTH: ow_reg <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // clamp to 1..max
  always_comb begin
    hf = (hf_reg == 0) ? FW'(1) : (32'(hf_reg) > MAX_FACTOR_D) ? FW'(MAX_FACTOR_D) : FW'(hf_reg);
    vf = (vf_reg == 0) ? FW'(1) : (32'(vf_reg) > MAX_FACTOR_D) ? FW'(MAX_FACTOR_D) : FW'(vf_reg);
    iw = (iw_reg == 0) ? DW'(1) : (32'(iw_reg) > MAX_IN_DIM) ? DW'(MAX_IN_DIM) : DW'(iw_reg);
    ih = (ih_reg == 0) ? DW'(1) : (32'(ih_reg) > MAX_IN_DIM) ? DW'(MAX_IN_DIM) : DW'(ih_reg);
    ow = (ow_reg == 0) ? OW'(1)
       : (32'(ow_reg) > MAX_OUT_WIDTH) ? OW'(MAX_OUT_WIDTH) : OW'(ow_reg);
  end

  logic accept;
  logic act, grp_end, emit;
  assign in_ready = !phase && !dbusy;
  assign accept = in_valid && in_ready;
  assign act = (out_col < ow);
  assign grp_end = (32'(pix_grp) + 1 >= 32'(hf));
  assign emit = act && grp_end && (32'(row_grp) + 1 >= 32'(vf));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      in_col <= '0;
      in_row <= '0;
      out_col <= '0;
      pix_grp <= '0;
      row_grp <= '0;
    end else if (accept) begin
      phase <= 1'b1;
      if (act) begin
        if (grp_end) begin
          pix_grp <= '0;
          out_col <= out_col + 1'b1;
        end else begin
          pix_grp <= pix_grp + 1'b1;
        end
      end
      if (32'(in_col) + 1 >= 32'(iw)) begin
        in_col <= '0;
        out_col <= '0;
        pix_grp <= '0;
        if (32'(in_row) + 1 >= 32'(ih)) begin
          in_row <= '0;
          row_grp <= '0;
        end else begin
          in_row <= in_row + 1'b1;
          row_grp <= (32'(row_grp) + 1 >= 32'(vf)) ? '0 : row_grp + 1'b1;
        end
      end else begin
        in_col <= in_col + 1'b1;
      end
    end else begin
      phase <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= mem[out_col[AW-1:0]];
      pr <= red_in;
      pg <= green_in;
      pb <= blue_in;
      p_first <= (row_grp == 0) && (pix_grp == 0);
      p_emit <= emit;
      p_active <= act;
      p_last <= (32'(out_col) + 1 == 32'(ow));
      p_addr <= out_col[AW-1:0];
    end
    if (phase && p_active) mem[p_addr] <= {sr, sg, sb};
  end

  always_comb begin
    sr = p_first ? SUM_W'(pr) : rdata[3*SUM_W-1:2*SUM_W] + SUM_W'(pr);
    sg = p_first ? SUM_W'(pg) : rdata[2*SUM_W-1:SUM_W] + SUM_W'(pg);
    sb = p_first ? SUM_W'(pb) : rdata[SUM_W-1:0] + SUM_W'(pb);
    req.red = sr;
    req.green = sg;
    req.blue = sb;
    req.den = SUM_W'(hf) * SUM_W'(vf);
    req.last = p_last;
  end
  assign dstart = phase && p_emit;

  rbd_divider u_div (
    .clk(clk), .rst(rst), .start(dstart), .req(req), .busy(dbusy), .done(ddone),
    .take(dtake), .red_q(qr), .green_q(qg), .blue_q(qb), .last(dlast)
  );

  assign dtake = ddone && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dtake) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (dtake) begin
      red_out <= qr;
      green_out <= qg;
      blue_out <= qb;
      line_end <= dlast;
    end
  end
endmodule

// File: design/rbd_divider.sv
// rbd_divider: restoring divider for three channel sums, one quotient bit per cycle.
// Depends on rbd_pkg.
`timescale 1ns / 1ps
module rbd_divider import rbd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  div_req_t req,
  output logic busy,
  output logic done,
  input  logic take,
  output logic [7:0] red_q,
  output logic [7:0] green_q,
  output logic [7:0] blue_q,
  output logic last
);
  localparam int CW = $clog2(SUM_W + 1);
  div_state_t state, state_next;
  logic [CW-1:0] count;
  logic [SUM_W-1:0] num [3];
  logic [SUM_W-1:0] rem [3];
  logic [SUM_W-1:0] den;
  logic [SUM_W:0] trial [3];

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: if (start) state_next = DIV_RUN;
      DIV_RUN: if (count == CW'(SUM_W - 1)) state_next = DIV_DONE;
      DIV_DONE: if (take) state_next = DIV_IDLE;
      default: state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != DIV_IDLE);
    done = (state == DIV_DONE);
  end

  always_comb begin
    for (int c = 0; c < 3; c++)
      trial[c] = {rem[c], num[c][SUM_W-1]} - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
    if (state == DIV_IDLE && start) begin
      num[0] <= req.red;
      num[1] <= req.green;
      num[2] <= req.blue;
      for (int c = 0; c < 3; c++) rem[c] <= '0;
      den <= req.den;
      last <= req.last;
      count <= '0;
    end else if (state == DIV_RUN) begin
      count <= count + 1'b1;
      for (int c = 0; c < 3; c++) begin
        if (!trial[c][SUM_W]) begin
          rem[c] <= trial[c][SUM_W-1:0];
          num[c] <= {num[c][SUM_W-2:0], 1'b1};
        end else begin
          rem[c] <= {rem[c][SUM_W-2:0], num[c][SUM_W-1]};
          num[c] <= {num[c][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  assign red_q = num[0][7:0];
  assign green_q = num[1][7:0];
  assign blue_q = num[2][7:0];
endmodule

// File: tb/sv/tb_rgb_box_downscaler.sv
// tb_rgb_box_downscaler: self-checking bench for the RGB box downscaler.
// Pixels are driven from a queue; a line-accumulator model
// predicts the averaged pixels. Depends on rbd_pkg and rgb_box_downscaler.
`timescale 1ns / 1ps
module tb_rgb_box_downscaler import rbd_pkg::*; ();

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
  } rgb_px_t;

  typedef struct {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit last;
  } avg_px_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] red_in = '0;
  logic [7:0] green_in = '0;
  logic [7:0] blue_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic line_end;

  rgb_box_downscaler u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .line_end(line_end)
  );

  always #1 clk = ~clk;

  rgb_px_t pixel_q[$];
  avg_px_t avg_q[$];
  idle_mode_t idle_mode = IDLE_NONE;
  bit in_taken = 1'b0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;
  int stall_cnt = 0;
  int errors = 0;

  // shadow registers and accumulator line of the model
  bit [4:0] hf_reg = 5'd1;
  bit [4:0] vf_reg = 5'd1;
  bit [12:0] iw_reg = 13'd1024;
  bit [12:0] ih_reg = 13'd1024;
  bit [10:0] ow_reg = 11'd1024;
  int unsigned acc_line[MAX_OUT_WIDTH_D][3];
  int unsigned col_cnt = 0;
  int unsigned row_cnt = 0;
  int unsigned ocol_cnt = 0;
  int unsigned px_grp = 0;
  int unsigned row_grp = 0;

  function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit box_step(rgb_px_t px, output avg_px_t res);
    int unsigned hf;
    int unsigned vf;
    int unsigned iw;
    int unsigned ih;
    int unsigned ow;
    int unsigned ch[3];
    bit first;
    bit got;
    hf = clamp_cfg(hf_reg, MAX_FACTOR_D);
    vf = clamp_cfg(vf_reg, MAX_FACTOR_D);
    iw = clamp_cfg(iw_reg, MAX_IN_DIM_D);
    ih = clamp_cfg(ih_reg, MAX_IN_DIM_D);
    ow = clamp_cfg(ow_reg, MAX_OUT_WIDTH_D);
    ch[0] = px.red;
    ch[1] = px.green;
    ch[2] = px.blue;
    got = 1'b0;
    res = '{default: 0};
    if (ocol_cnt < ow) begin
      first = (row_grp == 0) && (px_grp == 0);
      for (int c = 0; c < 3; c++)
        acc_line[ocol_cnt][c] = first ? ch[c] : acc_line[ocol_cnt][c] + ch[c];
      if (px_grp + 1 >= hf) begin
        if (row_grp + 1 >= vf) begin
          res.red = 8'(acc_line[ocol_cnt][0] / (hf * vf));
          res.green = 8'(acc_line[ocol_cnt][1] / (hf * vf));
          res.blue = 8'(acc_line[ocol_cnt][2] / (hf * vf));
          res.last = (ocol_cnt + 1 == ow);
          got = 1'b1;
        end
        px_grp = 0;
        ocol_cnt++;
      end else begin
        px_grp++;
      end
    end
    if (col_cnt + 1 >= iw) begin
      col_cnt = 0;
      ocol_cnt = 0;
      px_grp = 0;
      if (row_cnt + 1 >= ih) begin
        row_cnt = 0;
        row_grp = 0;
      end else begin
        row_cnt++;
        row_grp = (row_grp + 1 >= vf) ? 0 : row_grp + 1;
      end
    end else begin
      col_cnt++;
    end
    return got;
  endfunction

  // driver: hold the beat until taken, then advance
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      if (pixel_q.size() > 0 &&
          !((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 80) ||
            (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 8))) begin
        in_valid <= 1'b1;
        red_in <= pixel_q[0].red;
        green_in <= pixel_q[0].green;
        blue_in <= pixel_q[0].blue;
        pixel_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (idle_mode == IDLE_RECV) begin
      out_ready <= ($urandom_range(0, 99) >= 80);
    end else if (idle_mode == IDLE_BOTH) begin
      out_ready <= ($urandom_range(0, 99) >= 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: predict on each input beat, check each output beat
  always @(posedge clk) begin
    rgb_px_t px;
    avg_px_t res;
    avg_px_t exp_px;
    bit out_beat;
    in_taken = in_valid && in_ready;
    out_beat = out_valid && out_ready;
    if (!rst) begin
      if (in_taken) begin
        px.red = red_in;
        px.green = green_in;
        px.blue = blue_in;
        if (box_step(px, res)) avg_q.push_back(res);
      end
      if (out_beat) begin
        if (avg_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected output beat r=%0d g=%0d b=%0d le=%0d",
                   $time, red_out, green_out, blue_out, line_end);
        end else begin
          exp_px = avg_q.pop_front();
          if (red_out !== exp_px.red || green_out !== exp_px.green ||
              blue_out !== exp_px.blue || line_end !== exp_px.last) begin
            errors++;
            $display({"%0t: mismatch expected r=%0d g=%0d b=%0d le=%0d",
                      " actual r=%0d g=%0d b=%0d le=%0d"},
                     $time, exp_px.red, exp_px.green, exp_px.blue, exp_px.last,
                     red_out, green_out, blue_out, line_end);
          end
        end
      end
      if (in_taken || out_beat ||
          (pixel_q.size() == 0 && !in_valid && avg_q.size() == 0)) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
          $display("%0t: no progress with %0d results outstanding", $time, avg_q.size());
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_q.size() > 0 || in_valid || avg_q.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic program_regs(int unsigned hf, int unsigned vf, int unsigned iw,
                              int unsigned ih, int unsigned ow, idle_mode_t mode);
    bit [CFG_W-1:0] vals[5];
    reg_index_t idx[5];
    @(posedge clk);
    idle_mode = mode;
    vals = '{CFG_W'(hf), CFG_W'(vf), CFG_W'(iw), CFG_W'(ih), CFG_W'(ow)};
    idx = '{REG_HFACTOR, REG_VFACTOR, REG_IN_WIDTH, REG_IN_HEIGHT, REG_OUT_WIDTH};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    hf_reg = 5'(hf);
    vf_reg = 5'(vf);
    iw_reg = 13'(iw);
    ih_reg = 13'(ih);
    ow_reg = 11'(ow);
  endtask

  function automatic int unsigned frame_pixels();
    return clamp_cfg(iw_reg, MAX_IN_DIM_D) * clamp_cfg(ih_reg, MAX_IN_DIM_D);
  endfunction

  task automatic queue_random(int unsigned n);
    rgb_px_t px;
    for (int unsigned i = 0; i < n; i++) begin
      px.red = $urandom_range(0, 255);
      px.green = $urandom_range(0, 255);
      px.blue = $urandom_range(0, 255);
      pixel_q.push_back(px);
    end
  endtask

  initial begin
    rgb_px_t px;
    int unsigned sent;
    int unsigned n;
    int unsigned hf;
    int unsigned vf;
    int unsigned ow;
    int unsigned iw;
    int unsigned ih;
    int phase;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: excess pixel per line, trailing row, saturated channels
    program_regs(2, 2, 5, 3, 2, IDLE_NONE);
    for (int i = 0; i < 15; i++) begin
      px.red = 8'hFF;
      px.green = 8'h00;
      px.blue = (i % 2 == 0) ? 8'hFF : 8'h00;
      pixel_q.push_back(px);
    end
    for (int i = 0; i < 5; i++) begin
      px.red = (i % 2 == 0) ? 8'h00 : 8'hFF;
      px.green = 8'hFF;
      px.blue = 8'(i * 60);
      pixel_q.push_back(px);
    end
    // zero registers count as one
    wait_drained();
    program_regs(0, 0, 0, 0, 0, IDLE_RECV);
    queue_random(4);

    // extremes
    wait_drained();
    program_regs(16, 16, 16, 16, 1, IDLE_BOTH);
    queue_random(frame_pixels());
    wait_drained();
    program_regs(31, 31, 20, 16, 2047, IDLE_SEND);
    queue_random(frame_pixels());

    sent = 0;
    phase = 0;
    while (sent < 350) begin
      wait_drained();
      hf = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
      vf = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
      ow = (hf > 4 || vf > 4) ? 1 : $urandom_range(1, 6);
      iw = clamp_cfg(hf, MAX_FACTOR_D) * ow + $urandom_range(0, 3);
      if ($urandom_range(0, 7) == 0 && iw > 1) iw = iw - 1;
      ih = clamp_cfg(vf, MAX_FACTOR_D) * $urandom_range(1, 2) + $urandom_range(0, 2);
      program_regs(hf, vf, iw, ih, ow, idle_mode_t'(phase % 4));
      n = frame_pixels() * $urandom_range(1, 2);
      queue_random(n);
      sent += n;
      if (phase == 0) hold_go = 1'b1;
      phase++;
    end

    wait_drained();
    if (errors == 0 && avg_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0t: %0d mismatches, %0d results never seen", $time, errors, avg_q.size());
      $display("tb: failure");
    end
    $finish;
  end
endmodule
